### design/cau_pkg.sv
// Shared types, constants and helpers for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

  // Default number of fraction bits in the operand format.
  localparam int CAU_FRAC_BITS = 16;

  // Quotient bits produced by the divider chain, one per cell.
  localparam int CAU_QBITS = 32;

  // Operation codes.
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // Saturated 32-bit value together with its overflow flag.
  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  // Item state handed from cell to cell down the divider chain.
  typedef struct packed {
    logic        valid;
    logic        is_div;
    logic        dz;
    logic        neg_re;
    logic        neg_im;
    logic        pov_re;
    logic        pov_im;
    logic [63:0] den;
    logic [63:0] rem_re;
    logic [63:0] rem_im;
    logic [31:0] w_re;
    logic [31:0] w_im;
    logic [31:0] dres_re;
    logic [31:0] dres_im;
    logic        dovf;
  } cell_t;

  // Clamp a wide signed value into the signed 32-bit range.
  function automatic sat_t sat32(input logic signed [64:0] v);
    sat_t s;
    if (v > 65'sd2147483647) begin
      s.ovf = 1'b1;
      s.val = 32'h7FFF_FFFF;
    end else if (v < -65'sd2147483648) begin
      s.ovf = 1'b1;
      s.val = 32'h8000_0000;
    end else begin
      s.ovf = 1'b0;
      s.val = v[31:0];
    end
    return s;
  endfunction

endpackage

### design/cau_front.sv
// Front end of the complex arithmetic unit: products, sums and divider setup.
// Depends on cau_pkg.
module cau_front #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [1:0]          cmd,
  input  logic signed [31:0]  a_re,
  input  logic signed [31:0]  a_im,
  input  logic signed [31:0]  b_re,
  input  logic signed [31:0]  b_im,
  output cau_pkg::cell_t      cell_out
);
  import cau_pkg::*;

  localparam int ShW = 32 - FRAC_BITS;

  // Stage A: the six partial products and the add/subtract sums.
  logic               va;
  logic [1:0]         cmd_a;
  logic signed [63:0] p_rr, p_ii, p_ir, p_ri, p_br2, p_bi2;
  logic signed [32:0] as_re, as_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_a <= cmd;
      p_rr  <= a_re * b_re;
      p_ii  <= a_im * b_im;
      p_ir  <= a_im * b_re;
      p_ri  <= a_re * b_im;
      p_br2 <= b_re * b_re;
      p_bi2 <= b_im * b_im;
      if (cmd == CMD_SUB) begin
        as_re <= 33'(a_re) - 33'(b_re);
        as_im <= 33'(a_im) - 33'(b_im);
      end else begin
        as_re <= 33'(a_re) + 33'(b_re);
        as_im <= 33'(a_im) + 33'(b_im);
      end
    end
  end

  // Stage B: combine products; direct results for add, subtract, multiply.
  logic               vb;
  logic               div_b;
  logic [31:0]        dres_re_b, dres_im_b;
  logic               dovf_b;
  logic               neg_re_b, neg_im_b;
  logic [63:0]        mag_re_b, mag_im_b, den_b;

  logic signed [64:0] mp_re, mp_im, dn_re, dn_im, sh_re, sh_im;
  sat_t               s_re, s_im;

  always_comb begin
    mp_re = 65'(p_rr) - 65'(p_ii);
    mp_im = 65'(p_ir) + 65'(p_ri);
    dn_re = 65'(p_rr) + 65'(p_ii);
    dn_im = 65'(p_ir) - 65'(p_ri);
    sh_re = mp_re >>> FRAC_BITS;
    sh_im = mp_im >>> FRAC_BITS;
    if (cmd_a == CMD_MUL) begin
      s_re = sat32(sh_re);
      s_im = sat32(sh_im);
    end else begin
      s_re = sat32(65'(as_re));
      s_im = sat32(65'(as_im));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_b     <= (cmd_a == CMD_DIV);
      dres_re_b <= s_re.val;
      dres_im_b <= s_im.val;
      dovf_b    <= s_re.ovf | s_im.ovf;
      neg_re_b  <= dn_re[64];
      neg_im_b  <= dn_im[64];
      mag_re_b  <= dn_re[64] ? 64'(-dn_re) : 64'(dn_re);
      mag_im_b  <= dn_im[64] ? 64'(-dn_im) : 64'(dn_im);
      den_b     <= 64'(p_br2) + 64'(p_bi2);
    end
  end

  // Stage C: integer-part overflow check and first partial remainder.
  logic [87:0] den_sh;

  always_comb begin
    den_sh = 88'(den_b) << ShW;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out.valid <= vb;
    end
    if (en) begin
      cell_out.is_div  <= div_b;
      cell_out.dz      <= (den_b == 64'd0);
      cell_out.neg_re  <= neg_re_b;
      cell_out.neg_im  <= neg_im_b;
      cell_out.pov_re  <= (88'(mag_re_b) >= den_sh);
      cell_out.pov_im  <= (88'(mag_im_b) >= den_sh);
      cell_out.den     <= den_b;
      cell_out.rem_re  <= mag_re_b >> ShW;
      cell_out.rem_im  <= mag_im_b >> ShW;
      cell_out.w_re    <= 32'(mag_re_b << FRAC_BITS);
      cell_out.w_im    <= 32'(mag_im_b << FRAC_BITS);
      cell_out.dres_re <= dres_re_b;
      cell_out.dres_im <= dres_im_b;
      cell_out.dovf    <= dovf_b;
    end
  end

endmodule

### design/cau_div_cell.sv
// One restoring-division cell: produces one quotient bit for each part.
// Depends on cau_pkg.
module cau_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  cau_pkg::cell_t cell_in,
  output cau_pkg::cell_t cell_out
);
  import cau_pkg::*;

  logic [64:0] r2_re, r2_im;
  logic        ge_re, ge_im;
  cell_t       cell_next;

  // Shift the next dividend bit in, subtract the divisor when it fits.
  always_comb begin
    r2_re = {cell_in.rem_re, cell_in.w_re[31]};
    r2_im = {cell_in.rem_im, cell_in.w_im[31]};
    ge_re = (r2_re >= {1'b0, cell_in.den});
    ge_im = (r2_im >= {1'b0, cell_in.den});
    cell_next        = cell_in;
    cell_next.rem_re = ge_re ? 64'(r2_re - {1'b0, cell_in.den}) : r2_re[63:0];
    cell_next.rem_im = ge_im ? 64'(r2_im - {1'b0, cell_in.den}) : r2_im[63:0];
    cell_next.w_re   = {cell_in.w_re[30:0], ge_re};
    cell_next.w_im   = {cell_in.w_im[30:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out.valid <= cell_in.valid;
    end
    if (en) begin
      cell_out.is_div  <= cell_next.is_div;
      cell_out.dz      <= cell_next.dz;
      cell_out.neg_re  <= cell_next.neg_re;
      cell_out.neg_im  <= cell_next.neg_im;
      cell_out.pov_re  <= cell_next.pov_re;
      cell_out.pov_im  <= cell_next.pov_im;
      cell_out.den     <= cell_next.den;
      cell_out.rem_re  <= cell_next.rem_re;
      cell_out.rem_im  <= cell_next.rem_im;
      cell_out.w_re    <= cell_next.w_re;
      cell_out.w_im    <= cell_next.w_im;
      cell_out.dres_re <= cell_next.dres_re;
      cell_out.dres_im <= cell_next.dres_im;
      cell_out.dovf    <= cell_next.dovf;
    end
  end

endmodule

### design/complex_arith_unit.sv
// Complex arithmetic unit: add, subtract, multiply, divide on Q-format parts.
// The pipeline has three front stages, 32 divider cells and one output register.
// Throughput is one item per cycle; the whole pipeline holds while the output
// register is full and stalled, and the input is stalled in that case.
// Synchronous reset clears all valid bits; the data registers are not reset.
// Depends on cau_pkg, cau_front and cau_div_cell.
module complex_arith_unit #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               overflow,
  output logic               div_by_zero
);
  import cau_pkg::*;

  logic  en;
  cell_t chain [0:CAU_QBITS];

  // The pipeline moves unless a finished item waits at a stalled output.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  cau_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .cmd      (cmd),
    .a_re     (a_re),
    .a_im     (a_im),
    .b_re     (b_re),
    .b_im     (b_im),
    .cell_out (chain[0])
  );

  // Row of division cells, one quotient bit per cell.
  for (genvar i = 0; i < CAU_QBITS; i++) begin : g_cell
    cau_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  // Final sign, saturation and flag selection.
  cell_t       last;
  logic [31:0] fin_re, fin_im;
  logic        fin_ovf, fin_dz;
  logic        o_re, o_im;
  logic [31:0] q_re, q_im;

  always_comb begin
    last = chain[CAU_QBITS];
    o_re = 1'b0;
    o_im = 1'b0;
    if (last.pov_re) begin
      o_re = 1'b1;
      q_re = last.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (last.neg_re) begin
      o_re = (last.w_re > 32'h8000_0000);
      q_re = o_re ? 32'h8000_0000 : 32'(-last.w_re);
    end else begin
      o_re = (last.w_re > 32'h7FFF_FFFF);
      q_re = o_re ? 32'h7FFF_FFFF : last.w_re;
    end
    if (last.pov_im) begin
      o_im = 1'b1;
      q_im = last.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (last.neg_im) begin
      o_im = (last.w_im > 32'h8000_0000);
      q_im = o_im ? 32'h8000_0000 : 32'(-last.w_im);
    end else begin
      o_im = (last.w_im > 32'h7FFF_FFFF);
      q_im = o_im ? 32'h7FFF_FFFF : last.w_im;
    end

    if (!last.is_div) begin
      fin_re  = last.dres_re;
      fin_im  = last.dres_im;
      fin_ovf = last.dovf;
      fin_dz  = 1'b0;
    end else if (last.dz) begin
      fin_re  = 32'd0;
      fin_im  = 32'd0;
      fin_ovf = 1'b0;
      fin_dz  = 1'b1;
    end else begin
      fin_re  = q_re;
      fin_im  = q_im;
      fin_ovf = o_re | o_im;
      fin_dz  = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re      <= fin_re;
      res_im      <= fin_im;
      overflow    <= fin_ovf;
      div_by_zero <= fin_dz;
    end
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for complex_arith_unit: add, subtract, multiply, divide.
// A queue-fed driver and a clocked monitor compare every result with an in-bench predictor.
// Depends on cau_pkg and the complex_arith_unit RTL.
module tb_top;
  import cau_pkg::*;

  localparam int FRAC = CAU_FRAC_BITS;
  localparam int LATENCY = 36;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] ar, ai, br, bi;
  } cplx_op_t;

  typedef struct {
    logic [31:0] re, im;
    logic        ovf, dz;
  } cplx_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = CMD_ADD;
  logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] res_re, res_im;
  logic overflow, div_by_zero;

  cplx_op_t  pending_ops[$];
  cplx_res_t expected_results[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_sender = 1'b0;
  bit stim_done = 1'b0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;

  complex_arith_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_re(res_re), .res_im(res_im),
    .overflow(overflow), .div_by_zero(div_by_zero)
  );

  always #6 clk = ~clk;

  // Clamp a wide signed value into 32 bits, raising the overflow flag.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Exact quotient num * 2^FRAC / den, truncated toward zero, then clamped.
  function automatic logic [31:0] divide_part(input logic signed [127:0] num,
                                              input logic signed [127:0] den,
                                              inout logic ovf);
    logic signed [127:0] mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FRAC) / den;
    if (num < 0) q = -q;
    return clamp32(q, ovf);
  endfunction

  // Work out the expected result of one complex operation.
  function automatic cplx_res_t complex_result(input cplx_op_t x);
    cplx_res_t r;
    logic signed [127:0] ar, ai, br, bi, pr, pi, den;
    logic ovf;
    ar = x.ar; ai = x.ai; br = x.br; bi = x.bi;
    ovf = 1'b0;
    r.dz = 1'b0;
    r.re = '0;
    r.im = '0;
    case (x.op)
      CMD_ADD: begin
        r.re = clamp32(ar + br, ovf);
        r.im = clamp32(ai + bi, ovf);
      end
      CMD_SUB: begin
        r.re = clamp32(ar - br, ovf);
        r.im = clamp32(ai - bi, ovf);
      end
      CMD_MUL: begin
        pr = ar * br - ai * bi;
        pi = ai * br + ar * bi;
        r.re = clamp32(pr >>> FRAC, ovf);
        r.im = clamp32(pi >>> FRAC, ovf);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.re = divide_part(ar * br + ai * bi, den, ovf);
          r.im = divide_part(ai * br - ar * bi, den, ovf);
        end
      end
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  // Operand part biased toward extremes, small values and random bits.
  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC;
      3: return $urandom_range(0, 15) - 8;
      4, 5: return 32'($signed($urandom_range(0, 2000000)) - 1000000) <<< 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(input logic [1:0] op, input logic [31:0] ar, ai, br, bi);
    cplx_op_t x;
    x.op = op; x.ar = ar; x.ai = ai; x.br = br; x.bi = bi;
    pending_ops.push_back(x);
  endtask

  // Driver: presents the next pending item, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) n_sent <= n_sent + 1;
      if (pending_ops.size() > 0 && !hold_sender &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        cplx_op_t x;
        x = pending_ops.pop_front();
        expected_results.push_back(complex_result(x));
        in_valid <= 1'b1;
        cmd <= x.op;
        a_re <= x.ar; a_im <= x.ai; b_re <= x.br; b_im <= x.bi;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern.
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      cplx_res_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h", $time, res_re, res_im);
        errors <= errors + 1;
      end else begin
        e = expected_results.pop_front();
        if (res_re !== e.re || res_im !== e.im || overflow !== e.ovf ||
            div_by_zero !== e.dz) begin
          $display({"%0t: mismatch expected re=%h im=%h ovf=%b dz=%b ",
                    "actual re=%h im=%h ovf=%b dz=%b"},
                   $time, e.re, e.im, e.ovf, e.dz, res_re, res_im, overflow, div_by_zero);
          errors <= errors + 1;
        end
        n_checked <= n_checked + 1;
      end
    end
  end

  // Watchdog: counts cycles in which no item moves on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout with %0d results outstanding", expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [31:0] ext[4];
    ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes on every operation, division by zero, saturation.
    for (int op = 0; op < 4; op++) begin
      push_op(2'(op), ext[0], ext[1], ext[0], ext[1]);
      push_op(2'(op), ext[1], ext[0], ext[1], ext[1]);
      push_op(2'(op), ext[3], ext[2], ext[3], ext[3]);
      push_op(2'(op), 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0);
    end
    push_op(CMD_DIV, ext[0], ext[0], 32'h1, 32'h0);
    push_op(CMD_DIV, ext[1], ext[2], 32'hFFFF_FFFF, 32'h0);
    push_op(CMD_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0003_0000, 32'h0);
    push_op(CMD_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0);
    push_op(CMD_DIV, ext[1], ext[1], ext[1], ext[1]);
    wait_drained();

    // Random phases with different idling mixes; one pause drains the pipe.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        3: begin send_idle_pct = 14; recv_stall_pct = 14; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 300; i++)
        push_op(2'($urandom_range(0, 3)), rand_part(), rand_part(),
                ($urandom_range(0, 15) == 0) ? 32'h0 : rand_part(),
                ($urandom_range(0, 15) == 0) ? 32'h0 : rand_part());
      if (ph == 3) begin
        while (pending_ops.size() > 150) @(posedge clk);
        hold_sender <= 1'b1;
        while (in_valid || expected_results.size() > 0) @(posedge clk);
        hold_sender <= 1'b0;
      end
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d items over all four operations, checked %0d results", n_sent, n_checked);
    $display("under free-running, sender-idle, receiver-stall and mixed handshake phases.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
